[hw/rtl/contiguous_page_run_allocator_defines.svh]
// assertion macros used by the allocator controller
// no dependencies; included by the files that carry assertions
`ifndef CONTIGUOUS_PAGE_RUN_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_PAGE_RUN_ALLOCATOR_DEFINES_SVH

// expr must never hold outside reset
`define CPRA_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

// ante implies cons in the same cycle
`define CPRA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// ante implies cons in the next cycle
`define CPRA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/cpra_pkg.sv]
// types, constants and codes of the contiguous page run allocator
// no dependencies
package cpra_pkg;

  localparam int unsigned NUM_PAGES_DEF   = 65536;
  localparam int unsigned PAGE_SHIFT      = 12;
  localparam int unsigned FIRST_PAGE_W    = 16;
  localparam int unsigned REQ_W           = 29;
  localparam int unsigned ADDR_W          = 28;
  localparam int unsigned PAGES_W         = REQ_W + 1 - PAGE_SHIFT;
  localparam int unsigned STATUS_W        = 2;
  localparam logic [FIRST_PAGE_W-1:0] FIRST_PAGE_RST = 16'd272;

  typedef logic [2:0] mark_t;
  localparam mark_t MARK_FREE  = 3'b000;
  localparam mark_t MARK_USED  = 3'b001;
  localparam mark_t MARK_START = 3'b010;
  localparam mark_t MARK_END   = 3'b100;
  localparam mark_t MARK_INIT  = MARK_USED | MARK_START | MARK_END;

  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NO_SPACE  = 2'd1;
  localparam status_t ST_ZERO      = 2'd2;
  localparam status_t ST_NOT_START = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef logic [1:0] wr_sel_t;
  localparam wr_sel_t WR_INIT  = 2'd0;
  localparam wr_sel_t WR_ALLOC = 2'd1;
  localparam wr_sel_t WR_FREE  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    ptr_inc;
    logic    seek_start;
    logic    run_clr;
    logic    run_inc;
    logic    mem_rd;
    logic    mem_wr;
    wr_sel_t wr_sel;
    logic    out_load;
    status_t out_status;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_free;
    logic oob;
    logic zero;
    logic mark_free;
    logic mark_start;
    logic mark_end;
    logic run_hit;
    logic ptr_last;
    logic at_hit;
  } dp_sts_t;

endpackage

[hw/rtl/cpra_in_if.sv]
// request channel of the allocator: valid/ready plus command payload
// depends on cpra_pkg
interface cpra_in_if;
  import cpra_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [REQ_W-1:0]  request_bytes;
  logic [ADDR_W-1:0] block_address;

  modport source (output valid, command, request_bytes, block_address, input ready);
  modport sink   (input valid, command, request_bytes, block_address, output ready);
endinterface

[hw/rtl/cpra_out_if.sv]
// result channel of the allocator: valid/ready plus status and address
// depends on cpra_pkg
interface cpra_out_if;
  import cpra_pkg::*;

  logic              valid;
  logic              ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0] granted_address;

  modport source (output valid, status, granted_address, input ready);
  modport sink   (input valid, status, granted_address, output ready);
endinterface

[hw/rtl/cpra_datapath.sv]
// allocator datapath: page mark memory, page pointer, run counter, result regs
// depends on cpra_pkg; driven by cpra_ctrl
module cpra_datapath #(
  parameter int unsigned NUM_PAGES = cpra_pkg::NUM_PAGES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cpra_pkg::FIRST_PAGE_W-1:0] cfg_wdata,
  input  logic                              in_command,
  input  logic [cpra_pkg::REQ_W-1:0]        in_request_bytes,
  input  logic [cpra_pkg::ADDR_W-1:0]       in_block_address,
  input  cpra_pkg::ctl_cmd_t                cmd,
  output cpra_pkg::dp_sts_t                 sts,
  output logic [cpra_pkg::STATUS_W-1:0]     out_status,
  output logic [cpra_pkg::ADDR_W-1:0]       out_granted_address
);
  import cpra_pkg::*;

  localparam int unsigned AW = $clog2(NUM_PAGES);
  localparam logic [AW-1:0] LAST_PAGE = AW'(NUM_PAGES - 1);

  logic [FIRST_PAGE_W-1:0] first_page_r;
  logic [AW-1:0]           ptr_r, ptr_nxt;
  logic [AW-1:0]           hit_r, start_r;
  logic [PAGES_W-1:0]      pages_r, run_r;
  logic                    free_r, oob_r, zero_r;
  mark_t                   rdata_r, wdata;
  status_t                 out_status_r;
  logic [ADDR_W-1:0]       out_granted_r;
  logic [AW-1:0]           run_start;
  logic [REQ_W:0]          bytes_up;
  logic [FIRST_PAGE_W-1:0] addr_page;
  logic                    load_oob;
  logic [AW+ADDR_W-1:0]    grant_wide;

  mark_t mem [NUM_PAGES];

  assign addr_page = in_block_address[ADDR_W-1:PAGE_SHIFT];
  assign bytes_up  = {1'b0, in_request_bytes} + (REQ_W+1)'((1 << PAGE_SHIFT) - 1);
  assign load_oob  = (in_command == OP_FREE) ? (32'(addr_page) >= 32'(NUM_PAGES))
                                             : (32'(first_page_r) >= 32'(NUM_PAGES));
  // first page of the run that ends at the pointer
  assign run_start = AW'(32'(ptr_r) + 32'd1 - 32'(pages_r));
  assign grant_wide = {{ADDR_W{1'b0}}, start_r} << PAGE_SHIFT;

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.load) begin
      ptr_nxt = (in_command == OP_FREE) ? AW'(addr_page) : AW'(first_page_r);
    end else if (cmd.seek_start) begin
      ptr_nxt = run_start;
    end else if (cmd.ptr_inc) begin
      ptr_nxt = ptr_r + AW'(1);
    end
  end

  always_comb begin
    case (cmd.wr_sel)
      WR_INIT:  wdata = MARK_INIT;
      WR_ALLOC: wdata = MARK_USED | ((ptr_r == start_r) ? MARK_START : MARK_FREE)
                                  | ((ptr_r == hit_r) ? MARK_END : MARK_FREE);
      default:  wdata = MARK_FREE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_page_r <= FIRST_PAGE_RST;
      ptr_r        <= '0;
    end else begin
      if (cfg_we) begin
        first_page_r <= cfg_wdata;
      end
      ptr_r <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      free_r  <= in_command;
      oob_r   <= load_oob;
      zero_r  <= (in_request_bytes == '0);
      pages_r <= bytes_up[REQ_W:PAGE_SHIFT];
    end
    if (cmd.run_clr) begin
      run_r <= '0;
    end else if (cmd.run_inc) begin
      run_r <= run_r + PAGES_W'(1);
    end
    if (cmd.seek_start) begin
      hit_r   <= ptr_r;
      start_r <= run_start;
    end
    if (cmd.out_load) begin
      out_status_r  <= cmd.out_status;
      out_granted_r <= (cmd.out_status == ST_OK && !free_r) ? grant_wide[ADDR_W-1:0] : '0;
    end
  end

  // single-port mark memory, addressed by the page pointer
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[ptr_r] <= wdata;
    end
    if (cmd.mem_rd) begin
      rdata_r <= mem[ptr_r];
    end
  end

  assign sts.is_free    = free_r;
  assign sts.oob        = oob_r;
  assign sts.zero       = zero_r;
  assign sts.mark_free  = (rdata_r == MARK_FREE);
  assign sts.mark_start = |(rdata_r & MARK_START);
  assign sts.mark_end   = |(rdata_r & MARK_END);
  assign sts.run_hit    = (PAGES_W'(run_r + PAGES_W'(1)) == pages_r);
  assign sts.ptr_last   = (ptr_r == LAST_PAGE);
  assign sts.at_hit     = (ptr_r == hit_r);

  assign out_status          = out_status_r;
  assign out_granted_address = out_granted_r;
endmodule

[hw/rtl/cpra_ctrl.sv]
// allocator controller: clearing pass, first-fit scan, run marking, free walk
// depends on cpra_pkg and the assertion macro header
`include "contiguous_page_run_allocator_defines.svh"

module cpra_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  cpra_pkg::dp_sts_t  sts,
  output cpra_pkg::ctl_cmd_t cmd
);
  import cpra_pkg::*;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECIDE = 4'd2;
  localparam logic [3:0] S_SREAD  = 4'd3;
  localparam logic [3:0] S_SCHK   = 4'd4;
  localparam logic [3:0] S_MARK   = 4'd5;
  localparam logic [3:0] S_FREAD  = 4'd6;
  localparam logic [3:0] S_FSTART = 4'd7;
  localparam logic [3:0] S_FCLR   = 4'd8;
  localparam logic [3:0] S_FNEXT  = 4'd9;
  localparam logic [3:0] S_RESP   = 4'd10;

  logic [3:0] state_r, state_nxt;
  status_t    st_r, st_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    st_nxt    = st_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.mem_wr = 1'b1;
        cmd.wr_sel = WR_INIT;
        if (sts.ptr_last) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!sts.is_free) begin
          if (sts.zero) begin
            st_nxt    = ST_ZERO;
            state_nxt = S_RESP;
          end else if (sts.oob) begin
            st_nxt    = ST_NO_SPACE;
            state_nxt = S_RESP;
          end else begin
            cmd.run_clr = 1'b1;
            state_nxt   = S_SREAD;
          end
        end else if (sts.oob) begin
          st_nxt    = ST_NOT_START;
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_FREAD;
        end
      end
      S_SREAD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_SCHK;
      end
      S_SCHK: begin
        if (sts.mark_free && sts.run_hit) begin
          cmd.seek_start = 1'b1;
          state_nxt      = S_MARK;
        end else begin
          // a used page restarts the run count at the next page
          cmd.run_inc = sts.mark_free;
          cmd.run_clr = !sts.mark_free;
          if (sts.ptr_last) begin
            st_nxt    = ST_NO_SPACE;
            state_nxt = S_RESP;
          end else begin
            cmd.ptr_inc = 1'b1;
            state_nxt   = S_SREAD;
          end
        end
      end
      S_MARK: begin
        cmd.mem_wr = 1'b1;
        cmd.wr_sel = WR_ALLOC;
        if (sts.at_hit) begin
          st_nxt    = ST_OK;
          state_nxt = S_RESP;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      S_FREAD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_FSTART;
      end
      S_FSTART: begin
        if (!sts.mark_start) begin
          st_nxt    = ST_NOT_START;
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_FCLR;
        end
      end
      S_FCLR: begin
        cmd.mem_wr = 1'b1;
        cmd.wr_sel = WR_FREE;
        // stop at the end mark, or at the table end if the mark is missing
        if (sts.mark_end || sts.ptr_last) begin
          st_nxt    = ST_OK;
          state_nxt = S_RESP;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_nxt   = S_FNEXT;
        end
      end
      S_FNEXT: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_FCLR;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = st_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      st_r        <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `CPRA_ASSERT_NEVER(a_rd_wr_excl, clk, rst_n, cmd.mem_rd && cmd.mem_wr, "memory read and write in one cycle")
  `CPRA_ASSERT_NEVER(a_no_overwrite, clk, rst_n, cmd.out_load && out_valid_r && !out_ready, "pending result overwritten")
  `CPRA_ASSERT_NEXT(a_accept_decide, clk, rst_n, in_valid && in_ready, state_r == S_DECIDE, "accepted item not decoded")
  `CPRA_ASSERT_NEXT(a_mark_done, clk, rst_n, state_r == S_MARK && sts.at_hit, state_r == S_RESP && st_r == ST_OK, "run end did not finish allocation")
  `CPRA_ASSERT_IMPL(a_clear_quiet, clk, rst_n, state_r == S_CLEAR, !in_ready && !cmd.out_load, "item taken during clearing pass")
endmodule

[hw/rtl/contiguous_page_run_allocator.sv]
// Contiguous page run allocator: after reset a clearing pass marks every page used,
// start and end; no item is taken until it ends (configuration writes are). An allocate
// item scans pages from first_page up to the end of the granted run, then marks the
// pages of the run; a free item clears the pages of the block. The single-port page mark
// memory allows one access per cycle with registered read data. A new item is taken while
// a result still waits on the output register. Depends on cpra_pkg, cpra_in_if,
// cpra_out_if, cpra_datapath and cpra_ctrl.
module contiguous_page_run_allocator #(
  parameter int unsigned NUM_PAGES = cpra_pkg::NUM_PAGES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cpra_pkg::FIRST_PAGE_W-1:0] cfg_wdata,
  cpra_in_if.sink                           in_ch,
  cpra_out_if.source                        out_ch
);
  import cpra_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  cpra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cpra_datapath #(
    .NUM_PAGES (NUM_PAGES)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_command          (in_ch.command),
    .in_request_bytes    (in_ch.request_bytes),
    .in_block_address    (in_ch.block_address),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_status          (out_ch.status),
    .out_granted_address (out_ch.granted_address)
  );
endmodule

[sim/contiguous_page_run_allocator_tb.sv]
// testbench for contiguous_page_run_allocator: drives allocate and free items, predicts
// status and granted address from its own page mark table and checks every result
// depends on cpra_pkg, cpra_in_if, cpra_out_if and the allocator rtl
module contiguous_page_run_allocator_tb;
  import cpra_pkg::*;

  localparam int unsigned PAGES       = NUM_PAGES_DEF;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  // allocations that would find no run, or whose search would walk further than this, are swapped for a free
  localparam int unsigned SCAN_BOUND  = 1024;
  localparam int unsigned WINDOW      = 64;

  typedef struct packed {
    status_t             status;
    logic [ADDR_W-1:0]   addr;
  } outcome_t;

  class alloc_scoreboard;
    mark_t                   marks [PAGES];
    logic [FIRST_PAGE_W-1:0] first_page;
    outcome_t                awaited [$];
    int unsigned             errors;
    int unsigned             results;
    int unsigned             tally [4];

    function new();
      foreach (marks[i]) marks[i] = MARK_INIT;
      first_page = FIRST_PAGE_RST;
      errors = 0;
      results = 0;
      foreach (tally[i]) tally[i] = 0;
    endfunction

    // first-fit search without touching the table; last is the hit page or the final page
    function void find_run(input int unsigned npages, output int unsigned last,
                           output bit hit);
      int unsigned run;
      run = 0;
      hit = 1'b0;
      last = PAGES - 1;
      for (int unsigned p = first_page; p < PAGES; p++) begin
        if (marks[p] != MARK_FREE) begin
          run = 0;
        end else begin
          run++;
          if (run == npages) begin
            hit = 1'b1;
            last = p;
            return;
          end
        end
      end
    endfunction

    function outcome_t note_input(input logic cmd, input logic [REQ_W-1:0] bytes,
                                  input logic [ADDR_W-1:0] addr);
      outcome_t    o;
      int unsigned npages;
      int unsigned last;
      int unsigned p;
      int unsigned base;
      bit          hit;
      bit          at_end;
      o.status = ST_OK;
      o.addr = '0;
      if (cmd == OP_ALLOC) begin
        npages = (32'(bytes) + 32'd4095) >> PAGE_SHIFT;
        if (bytes == '0) begin
          o.status = ST_ZERO;
        end else begin
          find_run(npages, last, hit);
          if (!hit) begin
            o.status = ST_NO_SPACE;
          end else begin
            base = last + 1 - npages;
            for (p = base; p <= last; p++) marks[p] = MARK_USED;
            marks[base] = marks[base] | MARK_START;
            marks[last] = marks[last] | MARK_END;
            o.addr = ADDR_W'(base << PAGE_SHIFT);
          end
        end
      end else begin
        p = addr >> PAGE_SHIFT;
        if (p >= PAGES) begin
          o.status = ST_NOT_START;
        end else if ((marks[p] & MARK_START) == MARK_FREE) begin
          o.status = ST_NOT_START;
        end else begin
          // clear through the end mark, never past the last page
          at_end = 1'b0;
          while (p < PAGES && !at_end) begin
            at_end = (marks[p] & MARK_END) != MARK_FREE;
            marks[p] = MARK_FREE;
            p++;
          end
        end
      end
      tally[o.status]++;
      awaited.push_back(o);
      return o;
    endfunction

    function void check(input status_t st, input logic [ADDR_W-1:0] ga);
      outcome_t w;
      results++;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result %0d with nothing awaited: status %0d address %h", results, st, ga);
        return;
      end
      w = awaited.pop_front();
      if (st !== w.status || ga !== w.addr) begin
        errors++;
        if (errors <= 10)
          $display("result %0d: expected status %0d address %h, got status %0d address %h",
                   results, w.status, w.addr, st, ga);
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    cfg_we;
  logic [FIRST_PAGE_W-1:0] cfg_wdata;
  int unsigned             cycles = 0;
  int unsigned             gap_pct = 0;
  int unsigned             stall_pct = 0;
  alloc_scoreboard         sb;
  logic [ADDR_W-1:0]       live_blocks [$];
  logic [FIRST_PAGE_W-1:0] phase_first [4];
  int unsigned             phase_gap [4] = '{0, 46, 0, 21};
  int unsigned             phase_stall [4] = '{0, 0, 46, 21};

  cpra_in_if  in_ch ();
  cpra_out_if out_ch ();

  contiguous_page_run_allocator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check(out_ch.status, out_ch.granted_address);
    out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // offers one item, returns once it is taken, with its predicted result
  task automatic send(input logic cmd, input logic [REQ_W-1:0] bytes,
                      input logic [ADDR_W-1:0] addr, output outcome_t o);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.request_bytes <= bytes;
    in_ch.block_address <= addr;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    o = sb.note_input(cmd, bytes, addr);
  endtask

  task automatic alloc(input logic [REQ_W-1:0] bytes);
    outcome_t o;
    send(OP_ALLOC, bytes, ADDR_W'($urandom), o);
    if (o.status == ST_OK) live_blocks.push_back(o.addr);
  endtask

  task automatic free_block(input logic [ADDR_W-1:0] addr);
    outcome_t o;
    send(OP_FREE, REQ_W'($urandom), addr, o);
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_first_page(input logic [FIRST_PAGE_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.first_page = v;
  endtask

  task automatic random_item();
    int unsigned       r;
    int unsigned       sel;
    int unsigned       npages;
    int unsigned       last;
    int unsigned       page;
    int unsigned       idx;
    bit                hit;
    logic [REQ_W-1:0]  bytes;
    logic [ADDR_W-1:0] addr;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      sel = $urandom_range(0, 99);
      if (sel < 85) begin
        npages = $urandom_range(1, 6);
        bytes = REQ_W'((npages - 1) * 4096 + $urandom_range(1, 4096));
      end else if (sel < 95) begin
        bytes = REQ_W'($urandom_range(1, 32'h1000_0000));
      end else begin
        bytes = '0;
      end
      if (bytes != '0) begin
        npages = (32'(bytes) + 32'd4095) >> PAGE_SHIFT;
        sb.find_run(npages, last, hit);
        // a long walk of the table would only cost time, so make room instead
        if (!hit || last - sb.first_page > SCAN_BOUND) r = 80;
      end
    end
    if (r < 45) begin
      alloc(bytes);
    end else if (r < 70 && live_blocks.size() != 0) begin
      idx = $urandom_range(0, live_blocks.size() - 1);
      addr = live_blocks[idx] | ADDR_W'($urandom_range(0, 4095));
      live_blocks.delete(idx);
      free_block(addr);
    end else if (r < 93) begin
      page = sb.first_page + $urandom_range(0, WINDOW - 1);
      if (page >= PAGES) page = PAGES - 1;
      free_block(ADDR_W'((page << PAGE_SHIFT) | $urandom_range(0, 4095)));
    end else begin
      free_block(ADDR_W'($urandom));
    end
  endtask

  initial begin
    sb = new();
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.command <= OP_ALLOC;
    in_ch.request_bytes <= '0;
    in_ch.block_address <= '0;
    phase_first[0] = 16'd0;
    phase_first[1] = FIRST_PAGE_RST;
    phase_first[2] = 16'($urandom_range(1024, 64000));
    phase_first[3] = 16'd65472;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // low end of the table; the write lands during the clearing pass
    set_first_page(16'd0);
    alloc('0);
    free_block(28'h000_0000);
    free_block(28'h000_0000);
    free_block(28'h000_2123);
    free_block(28'h000_3000);
    free_block(28'h000_4fff);
    // page 1 is still used, so the run restarts at page 2
    alloc(29'd4097);
    alloc(29'd1);
    free_block(28'h000_2000);
    free_block(28'h000_3000);
    alloc(29'd12288);
    // middle page of a block has no start mark
    free_block(28'h000_3000);
    free_block(28'h000_2000);
    free_block(28'h000_0000);
    live_blocks.delete();
    wait_drain();

    // top end: only the last page may be granted, runs never wrap
    set_first_page(16'hffff);
    gap_pct = 21;
    stall_pct = 21;
    free_block(28'hfff_ffff);
    alloc(29'd8192);
    alloc(29'h1000_0000);
    alloc(29'd4096);
    alloc(29'd1);
    free_block(28'hfff_f000);
    live_blocks.delete();

    for (int ph = 0; ph < 4; ph++) begin
      wait_drain();
      set_first_page(phase_first[ph]);
      gap_pct = phase_gap[ph];
      stall_pct = phase_stall[ph];
      repeat (20) begin
        if ($urandom_range(0, 99) < 4) wait_drain();
        random_item();
      end
    end
    wait_drain();

    $display("%0d items checked: %0d ok, %0d out of space, %0d zero size, %0d bad frees",
             sb.results, sb.tally[ST_OK], sb.tally[ST_NO_SPACE], sb.tally[ST_ZERO],
             sb.tally[ST_NOT_START]);
    $display("search start swept from page 0 to 65535 across six settings, %0d mismatches",
             sb.errors);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
